[sv/ctd_pkg.sv]
// ctd_pkg: shared types and constants for the capacitive touch key detector.
// Holds the microcode word layout, the control and status structs and the fixed constants.
// No dependencies.
package ctd_pkg;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_CAL_LOAD,
    UOP_CAL_MIN,
    UOP_CAL_MAX,
    UOP_CAL_SUB_MIN1,
    UOP_CAL_SUB_MIN2,
    UOP_CAL_SUB_MAX1,
    UOP_CAL_SUB_MAX2,
    UOP_CAL_DIV,
    UOP_CAL_EMIT,
    UOP_SCAN_QUAL,
    UOP_SCAN_PEAK,
    UOP_SCAN_KEEP,
    UOP_SCAN_LOW,
    UOP_SCAN_EMIT
  } uop_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_IDLE,
    BR_IDLE_IF,
    BR_GOTO_IF
  } br_t;

  typedef struct packed {
    uop_t op;
    br_t  br;
    pc_t  target;
  } uword_t;

  typedef struct packed {
    logic run;
    uop_t op;
  } ctrl_t;

  typedef struct packed {
    logic flag;
    logic stall;
  } stat_t;

  localparam pc_t PC_CAL  = 4'd0;
  localparam pc_t PC_SCAN = 4'd9;

  localparam logic       FUNC_CAL  = 1'b0;
  localparam logic       FUNC_SCAN = 1'b1;
  localparam logic       KIND_CAL  = 1'b0;
  localparam logic       KIND_SCAN = 1'b1;

  localparam logic [3:0] CAL_SAMPLES = 4'd10;
  localparam logic [2:0] LEN_SINGLE  = 3'd3;
  localparam logic [2:0] LEN_CONT    = 3'd6;
  localparam logic [2:0] NEED_SINGLE = 3'd2;
  localparam logic [2:0] NEED_CONT   = 3'd4;

  localparam int FIELD_W = 16;
  localparam int OUT_W   = 40;

endpackage

[sv/ctd_urom.sv]
// ctd_urom: microprogram store of the detector, one control word per step.
// Depends on ctd_pkg.
module ctd_urom (
  input  ctd_pkg::pc_t   pc,
  output ctd_pkg::uword_t uword
);
  import ctd_pkg::*;

  always_comb begin
    unique case (pc)
      4'd0:    uword = '{op: UOP_CAL_LOAD,     br: BR_NEXT,    target: PC_CAL};
      4'd1:    uword = '{op: UOP_CAL_MIN,      br: BR_NEXT,    target: PC_CAL};
      4'd2:    uword = '{op: UOP_CAL_MAX,      br: BR_IDLE_IF, target: PC_CAL};
      4'd3:    uword = '{op: UOP_CAL_SUB_MIN1, br: BR_NEXT,    target: PC_CAL};
      4'd4:    uword = '{op: UOP_CAL_SUB_MIN2, br: BR_NEXT,    target: PC_CAL};
      4'd5:    uword = '{op: UOP_CAL_SUB_MAX1, br: BR_NEXT,    target: PC_CAL};
      4'd6:    uword = '{op: UOP_CAL_SUB_MAX2, br: BR_NEXT,    target: PC_CAL};
      4'd7:    uword = '{op: UOP_CAL_DIV,      br: BR_NEXT,    target: PC_CAL};
      4'd8:    uword = '{op: UOP_CAL_EMIT,     br: BR_IDLE,    target: PC_CAL};
      4'd9:    uword = '{op: UOP_SCAN_QUAL,    br: BR_NEXT,    target: PC_CAL};
      4'd10:   uword = '{op: UOP_SCAN_PEAK,    br: BR_IDLE_IF, target: PC_CAL};
      4'd11:   uword = '{op: UOP_SCAN_KEEP,    br: BR_NEXT,    target: PC_CAL};
      4'd12:   uword = '{op: UOP_SCAN_LOW,     br: BR_NEXT,    target: PC_CAL};
      4'd13:   uword = '{op: UOP_SCAN_EMIT,    br: BR_IDLE,    target: PC_CAL};
      default: uword = '{op: UOP_NOP,          br: BR_IDLE,    target: PC_CAL};
    endcase
  end

endmodule

[sv/ctd_seq.sv]
// ctd_seq: step counter and branch unit of the microcoded control.
// Depends on ctd_pkg; driven by the word from ctd_urom and the datapath status.
module ctd_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_accept,
  input  logic             in_func,
  input  ctd_pkg::uword_t  uword,
  input  ctd_pkg::stat_t   stat,
  output ctd_pkg::pc_t     pc,
  output ctd_pkg::ctrl_t   ctrl,
  output logic             ready
);
  import ctd_pkg::*;

  pc_t  pc_r, pc_nxt;
  logic busy_r, busy_nxt;

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (in_accept) begin
        busy_nxt = 1'b1;
        pc_nxt   = (in_func == FUNC_SCAN) ? PC_SCAN : PC_CAL;
      end
    end else if (!stat.stall) begin
      unique case (uword.br)
        BR_NEXT:    pc_nxt = pc_r + PC_W'(1);
        BR_IDLE:    busy_nxt = 1'b0;
        BR_IDLE_IF: begin
          if (stat.flag) busy_nxt = 1'b0;
          else           pc_nxt = pc_r + PC_W'(1);
        end
        BR_GOTO_IF: pc_nxt = stat.flag ? uword.target : pc_r + PC_W'(1);
        default:    busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= PC_CAL;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign pc       = pc_r;
  assign ctrl.run = busy_r;
  assign ctrl.op  = uword.op;
  assign ready    = !busy_r;

endmodule

[sv/ctd_dp.sv]
// ctd_dp: datapath of the detector: calibration min/max/sum, divide by six,
// scan round tracking, press decision, lockout and the output register. Depends on ctd_pkg.
module ctd_dp #(
  parameter int SAMPLE_BITS    = 16,
  parameter int LOCKOUT_ROUNDS = 3
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      in_accept,
  input  logic [SAMPLE_BITS-1:0]    in_sample,
  input  ctd_pkg::ctrl_t            ctrl,
  output ctd_pkg::stat_t            stat,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic                      out_kind,
  output logic [ctd_pkg::FIELD_W-1:0] out_baseline,
  output logic [ctd_pkg::FIELD_W-1:0] out_peak,
  output logic                      out_pressed
);
  import ctd_pkg::*;

  localparam int SW    = SAMPLE_BITS;
  localparam int SUM_W = SW + 4;
  localparam int X_W   = SW + 2;
  localparam int K     = SW + 3;
  localparam int LK_W  = $clog2(LOCKOUT_ROUNDS + 1);
  localparam logic [X_W-1:0] RECIP = X_W'(((64'd1 << K) + 64'd2) / 64'd3);

  logic            mode_r, mode_nxt;
  logic [SW-1:0]   smp_r, smp_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SW-1:0]   min1_r, min1_nxt, min2_r, min2_nxt;
  logic [SW-1:0]   max1_r, max1_nxt, max2_r, max2_nxt;
  logic [3:0]      ccnt_r, ccnt_nxt;
  logic [SW-1:0]   idle_r, idle_nxt;
  logic [2:0]      rcnt_r, rcnt_nxt;
  logic [SW-1:0]   peak_r, peak_nxt;
  logic [2:0]      qcnt_r, qcnt_nxt;
  logic [LK_W-1:0] lock_r, lock_nxt;
  logic [SW-1:0]   pk_r, pk_nxt;
  logic            lo_r, lo_nxt;
  logic            ov_r, ov_nxt;
  logic            okind_r, okind_nxt;
  logic [FIELD_W-1:0] obase_r, obase_nxt, opeak_r, opeak_nxt;
  logic            opress_r, opress_nxt;

  logic [3:0]      ccnt_inc;
  logic [2:0]      rcnt_inc, len, need;
  logic [SW+2:0]   s4, b5, p3, b4;
  logic [SW+3:0]   b10;
  logic            qual, lo_ok, hi_ok, in_range, is_emit, act;
  logic            flag, stall;
  logic [X_W-1:0]  half;
  logic [2*X_W-1:0] prod;

  assign ccnt_inc = ccnt_r + 4'd1;
  assign rcnt_inc = rcnt_r + 3'd1;
  assign len      = mode_r ? LEN_CONT : LEN_SINGLE;
  assign need     = mode_r ? NEED_CONT : NEED_SINGLE;

  // floor compares done by cross-multiplying
  assign s4    = {1'b0, smp_r, 2'b00};
  assign b5    = ({3'b000, idle_r} << 2) + {3'b000, idle_r};
  assign qual  = s4 > b5;
  assign p3    = ({3'b000, pk_r} << 1) + {3'b000, pk_r};
  assign b4    = {1'b0, idle_r, 2'b00};
  assign lo_ok = p3 > b4;
  assign b10   = ({4'b0000, idle_r} << 3) + ({4'b0000, idle_r} << 1);
  assign hi_ok = {4'b0000, pk_r} < b10;
  assign in_range = lo_r && hi_ok;

  // divide by six: halve, then multiply by a rounded-up reciprocal of three
  assign half = sum_r[SW+2:1];
  assign prod = (2*X_W)'(half) * (2*X_W)'(RECIP);

  assign is_emit = (ctrl.op == UOP_CAL_EMIT) || (ctrl.op == UOP_SCAN_EMIT);
  assign stall   = ctrl.run && is_emit && ov_r && !out_ready;
  assign act     = ctrl.run && !stall;
  assign stat    = '{flag: flag, stall: stall};

  always_comb begin
    unique case (ctrl.op)
      UOP_CAL_MAX:   flag = ccnt_inc != CAL_SAMPLES;
      UOP_SCAN_PEAK: flag = rcnt_inc < len;
      default:       flag = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt   = cfg_we ? cfg_wdata : mode_r;
    smp_nxt    = in_accept ? in_sample : smp_r;
    sum_nxt    = sum_r;
    min1_nxt   = min1_r;
    min2_nxt   = min2_r;
    max1_nxt   = max1_r;
    max2_nxt   = max2_r;
    ccnt_nxt   = ccnt_r;
    idle_nxt   = idle_r;
    rcnt_nxt   = rcnt_r;
    peak_nxt   = peak_r;
    qcnt_nxt   = qcnt_r;
    lock_nxt   = lock_r;
    pk_nxt     = pk_r;
    lo_nxt     = lo_r;
    ov_nxt     = ov_r && !out_ready;
    okind_nxt  = okind_r;
    obase_nxt  = obase_r;
    opeak_nxt  = opeak_r;
    opress_nxt = opress_r;
    if (act) begin
      unique case (ctrl.op)
        UOP_CAL_LOAD: begin
          if (ccnt_r == 4'd0) begin
            sum_nxt  = SUM_W'(smp_r);
            min1_nxt = '1;
            min2_nxt = '1;
            max1_nxt = '0;
            max2_nxt = '0;
          end else begin
            sum_nxt = sum_r + SUM_W'(smp_r);
          end
        end
        UOP_CAL_MIN: begin
          if (smp_r < min1_r) begin
            min2_nxt = min1_r;
            min1_nxt = smp_r;
          end else if (smp_r < min2_r) begin
            min2_nxt = smp_r;
          end
        end
        UOP_CAL_MAX: begin
          if (smp_r > max1_r) begin
            max2_nxt = max1_r;
            max1_nxt = smp_r;
          end else if (smp_r > max2_r) begin
            max2_nxt = smp_r;
          end
          ccnt_nxt = (ccnt_inc == CAL_SAMPLES) ? 4'd0 : ccnt_inc;
        end
        UOP_CAL_SUB_MIN1: sum_nxt = sum_r - SUM_W'(min1_r);
        UOP_CAL_SUB_MIN2: sum_nxt = sum_r - SUM_W'(min2_r);
        UOP_CAL_SUB_MAX1: sum_nxt = sum_r - SUM_W'(max1_r);
        UOP_CAL_SUB_MAX2: sum_nxt = sum_r - SUM_W'(max2_r);
        UOP_CAL_DIV:      sum_nxt = SUM_W'(prod[K+SW-1:K]);
        UOP_CAL_EMIT: begin
          idle_nxt   = sum_r[SW-1:0];
          ov_nxt     = 1'b1;
          okind_nxt  = KIND_CAL;
          obase_nxt  = FIELD_W'(sum_r[SW-1:0]);
          opeak_nxt  = '0;
          opress_nxt = 1'b0;
        end
        UOP_SCAN_QUAL: begin
          if (qual) qcnt_nxt = qcnt_r + 3'd1;
        end
        UOP_SCAN_PEAK: begin
          if (smp_r > peak_r) peak_nxt = smp_r;
          rcnt_nxt = rcnt_inc;
        end
        UOP_SCAN_KEEP: begin
          pk_nxt   = (qcnt_r >= need) ? peak_r : '0;
          rcnt_nxt = 3'd0;
          peak_nxt = '0;
          qcnt_nxt = 3'd0;
          if (mode_r) lock_nxt = '0;
        end
        UOP_SCAN_LOW: lo_nxt = lo_ok;
        UOP_SCAN_EMIT: begin
          if (in_range)            lock_nxt = LK_W'(LOCKOUT_ROUNDS - 1);
          else if (lock_r != '0)   lock_nxt = lock_r - LK_W'(1);
          ov_nxt     = 1'b1;
          okind_nxt  = KIND_SCAN;
          obase_nxt  = FIELD_W'(idle_r);
          opeak_nxt  = FIELD_W'(pk_r);
          opress_nxt = in_range && (lock_r == '0);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      ccnt_r <= 4'd0;
      idle_r <= '0;
      rcnt_r <= 3'd0;
      peak_r <= '0;
      qcnt_r <= 3'd0;
      lock_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      ccnt_r <= ccnt_nxt;
      idle_r <= idle_nxt;
      rcnt_r <= rcnt_nxt;
      peak_r <= peak_nxt;
      qcnt_r <= qcnt_nxt;
      lock_r <= lock_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    smp_r    <= smp_nxt;
    sum_r    <= sum_nxt;
    min1_r   <= min1_nxt;
    min2_r   <= min2_nxt;
    max1_r   <= max1_nxt;
    max2_r   <= max2_nxt;
    pk_r     <= pk_nxt;
    lo_r     <= lo_nxt;
    okind_r  <= okind_nxt;
    obase_r  <= obase_nxt;
    opeak_r  <= opeak_nxt;
    opress_r <= opress_nxt;
  end

  assign out_valid    = ov_r;
  assign out_kind     = okind_r;
  assign out_baseline = obase_r;
  assign out_peak     = opeak_r;
  assign out_pressed  = opress_r;

endmodule

[sv/capacitive_touch_key_detector.sv]
// capacitive_touch_key_detector: top level; uses ctd_pkg, ctd_urom, ctd_seq, ctd_dp.
// Each request is one charge-time sample. Calibration samples (tuser 0) are collected ten
// at a time; the tenth yields a result carrying the new baseline, the mean of the middle six.
// Scan samples (tuser 1) form rounds of three, or six with continuous_mode set; each finished
// round yields a result with the qualified peak and a press flag. A short microprogram runs
// one step per cycle and takes no new request while busy. Scan samples run qualify and peak;
// calibration samples run load, min and max; a round's end adds keep, low and emit, and the
// tenth calibration sample adds steps that drop the two lowest and two highest samples, divide
// by six and emit. A finished result sits in the output register and a new request is taken
// meanwhile; the program waits at its final step only if the previous result is not yet taken.
module capacitive_touch_key_detector #(
  parameter int SAMPLE_BITS    = 16,
  parameter int LOCKOUT_ROUNDS = 3
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic                                  cfg_wdata,   // continuous_mode
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,  // sample
  input  logic                                  in_tuser,    // func
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ctd_pkg::OUT_W-1:0]             out_tdata,   // baseline, peak, pressed
  output logic                                  out_tuser    // result_kind
);
  import ctd_pkg::*;

  pc_t    pc;
  uword_t uword;
  ctrl_t  ctrl;
  stat_t  stat;
  logic   in_accept;
  logic   out_pressed;
  logic [FIELD_W-1:0] out_baseline, out_peak;

  assign in_accept = in_tvalid && in_tready;

  ctd_urom u_urom (
    .pc    (pc),
    .uword (uword)
  );

  ctd_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_func   (in_tuser),
    .uword     (uword),
    .stat      (stat),
    .pc        (pc),
    .ctrl      (ctrl),
    .ready     (in_tready)
  );

  ctd_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .LOCKOUT_ROUNDS (LOCKOUT_ROUNDS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_accept    (in_accept),
    .in_sample    (in_tdata[SAMPLE_BITS-1:0]),
    .ctrl         (ctrl),
    .stat         (stat),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_kind     (out_tuser),
    .out_baseline (out_baseline),
    .out_peak     (out_peak),
    .out_pressed  (out_pressed)
  );

  assign out_tdata = {{(OUT_W - 2 * FIELD_W - 1){1'b0}}, out_pressed, out_peak, out_baseline};

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("request taken while microprogram running");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.stall |-> (out_tvalid && !out_tready))
    else $error("program stalled with free output slot");

  a_press_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_pressed) |-> (out_tuser == KIND_SCAN))
    else $error("press flagged on calibration result");

  a_cal_peak_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_CAL)) |-> (out_peak == '0))
    else $error("calibration result carries a peak");

endmodule
